@@ sv/vector_cosine_similarity_core_defines.svh @@
// assertion macros for the vector cosine similarity rtl
// no dependencies
`ifndef VECTOR_COSINE_SIMILARITY_CORE_DEFINES_SVH
`define VECTOR_COSINE_SIMILARITY_CORE_DEFINES_SVH

// same-cycle implication
`define VCS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/vcs_pkg.sv @@
// types and constants for the vector cosine similarity core
// no dependencies
`default_nettype none

package vcs_pkg;

   localparam int ELEM_W   = 16;
   localparam int KIND_W   = 2;
   localparam int DOT_W    = 44;
   localparam int SQ_W     = 43;
   localparam int ROOT_W   = 44;
   localparam int DEN_W    = 44;
   localparam int NUM_W    = 59;
   localparam int CNT_W    = 6;
   localparam int SQRT_STEPS = 22;
   localparam int DIV_STEPS  = 59;

   localparam logic [KIND_W-1:0] KIND_IMAGE = 2'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SQRT,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic acc;
      logic sqrt_init;
      logic sqrt_step;
      logic mul;
      logic prep;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic special;
   } status_type;

endpackage

`default_nettype wire

@@ sv/vector_cosine_similarity_core.sv @@
// top level of the vector cosine similarity core
// depends on vcs_pkg, vcs_ctrl and vcs_datapath
//
// req channel: one beat per element pair, tdata carries elem_a and elem_b,
// tuser the two object kinds, tlast marks the final pair of the vectors.
// rsp channel: one beat per vector pair, tdata the similarity in q1.15,
// tuser the zero norm and kind mismatch flags.
// a beat without tlast is taken while idle; the next beat may follow at once.
// a tlast beat starts the finish sequence: one check step, the two square
// roots in parallel, one multiply, one setup and a one-bit-per-cycle
// divider, then the result beat.
// a kind mismatch or zero norm skips the roots and divider.
// req_tready stays low during the finish sequence.
// the result is held in an output register; a stalled receiver holds it,
// while new pairs are still taken; a further result waits until the held
// beat is taken.
// reset clears the controller and the sums are cleared after every result.
`default_nettype none

module vector_cosine_similarity_core
   import vcs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // elem_a, elem_b
   input  wire logic [3:0]  req_tuser,   // kind_a, kind_b
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // similarity
   output logic [1:0]       rsp_tuser    // zero_norm, kind_mismatch
);

   cmd_type                  cmd;
   status_type               status;
   logic signed [ELEM_W-1:0] similarity;
   logic                     zero_norm;
   logic                     kind_mismatch;

   vcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vcs_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .elem_a        (req_tdata[15:0]),
      .elem_b        (req_tdata[31:16]),
      .kind_a        (req_tuser[1:0]),
      .kind_b        (req_tuser[3:2]),
      .last_pair     (req_tlast),
      .status        (status),
      .similarity    (similarity),
      .zero_norm     (zero_norm),
      .kind_mismatch (kind_mismatch)
   );

   assign rsp_tdata = similarity;
   assign rsp_tuser = {kind_mismatch, zero_norm};

endmodule

`default_nettype wire

@@ sv/vcs_ctrl.sv @@
// controller state machine of the vector cosine similarity core
// depends on vcs_pkg and the assertion macros
`default_nettype none
`include "vector_cosine_similarity_core_defines.svh"

module vcs_ctrl
   import vcs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tlast,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      req_tready   = (state_ff == ST_IDLE);
      accept       = req_tvalid && req_tready;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.acc      = accept;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tlast) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.special) begin
               state_in = ST_FINISH;
            end else begin
               cmd.sqrt_init = 1'b1;
               cnt_in        = CNT_W'(SQRT_STEPS - 1);
               state_in      = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = CNT_W'(DIV_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   `VCS_ASSERT_NOW(a_ready_idle, clock, reset, req_tready, state_ff == ST_IDLE, "ready outside idle")
   `VCS_ASSERT_NEXT(a_finish_leaves, clock, reset, state_ff == ST_FINISH && out_free, state_ff == ST_IDLE && rsp_tvalid, "finish did not load result")
   `VCS_ASSERT_NEXT(a_sqrt_end, clock, reset, state_ff == ST_SQRT && cnt_ff == '0, state_ff == ST_MUL, "square root length wrong")

endmodule

`default_nettype wire

@@ sv/vcs_datapath.sv @@
// accumulators, square roots, multiplier and divider of the cosine similarity core
// depends on vcs_pkg, driven by vcs_ctrl
`default_nettype none

module vcs_datapath
   import vcs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire logic signed [ELEM_W-1:0] elem_a,
   input  wire logic signed [ELEM_W-1:0] elem_b,
   input  wire logic [KIND_W-1:0]        kind_a,
   input  wire logic [KIND_W-1:0]        kind_b,
   input  wire logic                     last_pair,
   output status_type                    status,
   output logic signed [ELEM_W-1:0]      similarity,
   output logic                          zero_norm,
   output logic                          kind_mismatch
);

   logic signed [DOT_W-1:0] dot_ff;
   logic [SQ_W-1:0]         sqa_ff, sqb_ff;
   logic                    mis_ff;
   logic [SQ_W-1:0]         xa_ff, xb_ff, bit_ff;
   logic [ROOT_W-1:0]       ra_ff, rb_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [NUM_W-1:0]        num_ff, quo_ff;
   logic [DEN_W:0]          rem_ff;
   logic                    neg_ff;
   logic signed [ELEM_W-1:0] sim_ff;
   logic                    zero_ff, mis_out_ff;

   logic signed [2*ELEM_W-1:0] pab;
   logic [2*ELEM_W-1:0]        paa, pbb;
   logic signed [DOT_W:0]      dot_sum;
   logic [SQ_W:0]              sqa_sum, sqb_sum;
   logic signed [DOT_W-1:0]    dot_in;
   logic [SQ_W-1:0]            sqa_in, sqb_in;
   logic                       zero_now;
   logic [ROOT_W:0]            trial_a, trial_b;
   logic [DEN_W-1:0]           mag;
   logic [DEN_W:0]             rem_sh;
   logic [ELEM_W-1:0]          sat_q;

   always_comb begin
      pab     = elem_a * elem_b;
      paa     = unsigned'((2*ELEM_W)'(elem_a) * (2*ELEM_W)'(elem_a));
      pbb     = unsigned'((2*ELEM_W)'(elem_b) * (2*ELEM_W)'(elem_b));
      dot_sum = (DOT_W+1)'(dot_ff) + (DOT_W+1)'(pab);
      if (dot_sum > (DOT_W+1)'(signed'({1'b0, {(DOT_W-1){1'b1}}}))) begin
         dot_in = {1'b0, {(DOT_W-1){1'b1}}};
      end else if (dot_sum < (DOT_W+1)'(signed'({1'b1, {(DOT_W-1){1'b0}}}))) begin
         dot_in = {1'b1, {(DOT_W-1){1'b0}}};
      end else begin
         dot_in = dot_sum[DOT_W-1:0];
      end
      sqa_sum = {1'b0, sqa_ff} + (SQ_W+1)'(paa);
      sqb_sum = {1'b0, sqb_ff} + (SQ_W+1)'(pbb);
      sqa_in  = sqa_sum[SQ_W] ? {SQ_W{1'b1}} : sqa_sum[SQ_W-1:0];
      sqb_in  = sqb_sum[SQ_W] ? {SQ_W{1'b1}} : sqb_sum[SQ_W-1:0];
      zero_now       = (sqa_ff == '0) || (sqb_ff == '0);
      status.special = mis_ff || zero_now;
      trial_a = {1'b0, ra_ff} + (ROOT_W+1)'(bit_ff);
      trial_b = {1'b0, rb_ff} + (ROOT_W+1)'(bit_ff);
      mag     = dot_ff[DOT_W-1] ? DEN_W'(-dot_ff) : DEN_W'(dot_ff);
      rem_sh  = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      if (neg_ff) begin
         sat_q = (quo_ff > NUM_W'(32768)) ? 16'h8000 : ELEM_W'(-quo_ff[ELEM_W-1:0]);
      end else begin
         sat_q = (quo_ff > NUM_W'(32767)) ? 16'h7fff : quo_ff[ELEM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         sqa_ff <= '0;
         sqb_ff <= '0;
      end else if (cmd.acc) begin
         dot_ff <= dot_in;
         sqa_ff <= sqa_in;
         sqb_ff <= sqb_in;
      end else if (cmd.load_out) begin
         dot_ff <= '0;
         sqa_ff <= '0;
         sqb_ff <= '0;
      end
      if (cmd.acc && last_pair) begin
         mis_ff <= (kind_a != kind_b) || (kind_a != KIND_IMAGE);
      end
      if (cmd.sqrt_init) begin
         xa_ff  <= sqa_ff;
         xb_ff  <= sqb_ff;
         ra_ff  <= '0;
         rb_ff  <= '0;
         bit_ff <= {1'b1, {(SQ_W-1){1'b0}}};
      end else if (cmd.sqrt_step) begin
         if ({1'b0, xa_ff} >= trial_a[SQ_W:0]) begin
            xa_ff <= xa_ff - trial_a[SQ_W-1:0];
            ra_ff <= (ra_ff >> 1) + ROOT_W'(bit_ff);
         end else begin
            ra_ff <= ra_ff >> 1;
         end
         if ({1'b0, xb_ff} >= trial_b[SQ_W:0]) begin
            xb_ff <= xb_ff - trial_b[SQ_W-1:0];
            rb_ff <= (rb_ff >> 1) + ROOT_W'(bit_ff);
         end else begin
            rb_ff <= rb_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.mul) begin
         den_ff <= ra_ff[SQRT_STEPS-1:0] * rb_ff[SQRT_STEPS-1:0];
      end
      if (cmd.prep) begin
         num_ff <= NUM_W'({mag, 15'b0}) + NUM_W'(den_ff >> 1);
         neg_ff <= dot_ff[DOT_W-1];
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
      if (cmd.load_out) begin
         priority if (mis_ff) begin
            sim_ff     <= '0;
            zero_ff    <= 1'b0;
            mis_out_ff <= 1'b1;
         end else if (zero_now) begin
            sim_ff     <= '0;
            zero_ff    <= 1'b1;
            mis_out_ff <= 1'b0;
         end else begin
            sim_ff     <= sat_q;
            zero_ff    <= 1'b0;
            mis_out_ff <= 1'b0;
         end
      end
   end

   assign similarity    = sim_ff;
   assign zero_norm     = zero_ff;
   assign kind_mismatch = mis_out_ff;

endmodule

`default_nettype wire

@@ tb/vector_cosine_similarity_core_checker.sv @@
// checker for the vector cosine similarity core: watches both streams,
// predicts each similarity beat and compares it; depends on vcs_pkg
`default_nettype none

module vector_cosine_similarity_core_checker
   import vcs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic [3:0]  req_tuser,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   output int               errors,
   output int               pending
);

   typedef struct packed {
      logic [15:0] similarity;
      logic        zero_norm;
      logic        kind_mismatch;
   } score_type;

   localparam longint DOT_HI = 64'sd8796093022207;
   localparam longint DOT_LO = -64'sd8796093022208;
   localparam longint SQ_HI  = 64'd8796093022207;

   longint dot_acc;
   longint sq_acc_a;
   longint sq_acc_b;
   score_type expected_scores[$];

   function automatic longint root_floor(input longint v);
      longint r, b, x;
      r = 0;
      x = v;
      b = 64'sd1 << 62;
      while (b > x) b = b >>> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] cosine_q15(input longint dot, input longint sa,
                                              input longint sb);
      logic   neg;
      longint mag, den, q;
      neg = dot < 0;
      mag = neg ? -dot : dot;
      den = root_floor(sa) * root_floor(sb);
      if (den == 0) return '0;
      q = ((mag << 15) + den / 2) / den;
      if (neg) return (q > 32768) ? 16'h8000 : 16'(-q);
      return (q > 32767) ? 16'h7fff : 16'(q);
   endfunction

   always_ff @(posedge clock) begin
      longint a, b, d;
      score_type s;
      if (reset) begin
         dot_acc  = 0;
         sq_acc_a = 0;
         sq_acc_b = 0;
         errors   <= 0;
         expected_scores.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            a = longint'($signed(req_tdata[15:0]));
            b = longint'($signed(req_tdata[31:16]));
            d = dot_acc + a * b;
            if (d > DOT_HI) d = DOT_HI;
            if (d < DOT_LO) d = DOT_LO;
            sq_acc_a = sq_acc_a + a * a;
            if (sq_acc_a > SQ_HI) sq_acc_a = SQ_HI;
            sq_acc_b = sq_acc_b + b * b;
            if (sq_acc_b > SQ_HI) sq_acc_b = SQ_HI;
            dot_acc = d;
            if (req_tlast) begin
               s = '0;
               if (req_tuser[1:0] != req_tuser[3:2] || req_tuser[1:0] != KIND_IMAGE)
                  s.kind_mismatch = 1'b1;
               else if (sq_acc_a == 0 || sq_acc_b == 0)
                  s.zero_norm = 1'b1;
               else
                  s.similarity = cosine_q15(dot_acc, sq_acc_a, sq_acc_b);
               expected_scores.insert(expected_scores.size(), s);
               dot_acc = 0;
               sq_acc_a = 0;
               sq_acc_b = 0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_scores.size() == 0) begin
               $display("%0t: unexpected beat %h/%b", $time, rsp_tdata, rsp_tuser);
               errors <= errors + 1;
            end else begin
               s = expected_scores.pop_front();
               if (s != {rsp_tdata, rsp_tuser[0], rsp_tuser[1]}) begin
                  $display("%0t: expected %h/%b actual %h/%b", $time, s.similarity,
                           {s.zero_norm, s.kind_mismatch}, rsp_tdata,
                           {rsp_tuser[0], rsp_tuser[1]});
                  errors <= errors + 1;
               end
            end
         end
      end
   end

   assign pending = expected_scores.size();

endmodule

`default_nettype wire

@@ tb/vector_cosine_similarity_core_tb.sv @@
// stimulus and verdict for the vector cosine similarity core
// depends on vcs_pkg, the core and vector_cosine_similarity_core_checker
`default_nettype none

module vector_cosine_similarity_core_tb
   import vcs_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          errors;
   int          pending;
   int          idle_cycles = 0;
   bit          stalls_on = 1'b1;

   always #5 clock = ~clock;

   vector_cosine_similarity_core dut (.*);
   vector_cosine_similarity_core_checker monitor (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver stalls in runs, with quiet stretches
   always @(negedge clock) begin
      if (!stalls_on) rsp_tready <= 1'b1;
      else if ($urandom_range(0, 7) == 0) rsp_tready <= ~rsp_tready;
      else if ($urandom_range(0, 3) == 0) rsp_tready <= $urandom_range(0, 2) != 0;
   end

   task automatic send_pair(input logic [15:0] a, input logic [15:0] b,
                            input logic [1:0] ka, input logic [1:0] kb, input logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= {kb, ka};
      req_tlast  <= last;
      while (!req_tready) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic maybe_gap();
      int n;
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic logic [15:0] pick_elem(input int style);
      case (style)
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom());
      endcase
   endfunction

   initial begin
      int count;
      int len;
      logic [1:0] ka, kb;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, both signs, zero norms, kind cases
      send_pair(16'h7fff, 16'h7fff, KIND_IMAGE, KIND_IMAGE, 1'b1);
      send_pair(16'h8000, 16'h8000, KIND_IMAGE, KIND_IMAGE, 1'b1);
      send_pair(16'h8000, 16'h7fff, KIND_IMAGE, KIND_IMAGE, 1'b1);
      send_pair(16'h0001, 16'hffff, KIND_IMAGE, KIND_IMAGE, 1'b1);
      send_pair(16'h0000, 16'h1234, KIND_IMAGE, KIND_IMAGE, 1'b1);
      send_pair(16'h1234, 16'h0000, KIND_IMAGE, KIND_IMAGE, 1'b1);
      send_pair(16'h0000, 16'h0000, KIND_IMAGE, KIND_IMAGE, 1'b1);
      send_pair(16'h4000, 16'h4000, 2'd1, 2'd1, 1'b1);
      send_pair(16'h4000, 16'h4000, KIND_IMAGE, 2'd3, 1'b1);
      send_pair(16'h4000, 16'h4000, 2'd2, KIND_IMAGE, 1'b1);
      send_pair(16'h3000, 16'h0100, 2'd3, 2'd2, 1'b0);
      send_pair(16'h0100, 16'h3000, KIND_IMAGE, KIND_IMAGE, 1'b1);
      send_pair(16'h0003, 16'h0001, KIND_IMAGE, KIND_IMAGE, 1'b0);
      send_pair(16'hfffd, 16'h0002, KIND_IMAGE, KIND_IMAGE, 1'b1);
      send_pair(16'h5555, 16'haaaa, KIND_IMAGE, KIND_IMAGE, 1'b1);
      // random vectors: mostly image pairs, some kind mismatches
      count = 0;
      while (count < 1450) begin
         if (count > 800 && count < 1200) stalls_on = 1'b0;
         else stalls_on = 1'b1;
         len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
         if ($urandom_range(0, 4) == 0) begin
            ka = 2'($urandom());
            kb = 2'($urandom());
         end else begin
            ka = KIND_IMAGE;
            kb = KIND_IMAGE;
         end
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
               0: send_pair(pick_elem($urandom_range(0, 3)), pick_elem($urandom_range(0, 3)),
                            2'($urandom()), 2'($urandom()), i == len - 1);
               default: send_pair(pick_elem($urandom_range(0, 3)),
                                  pick_elem($urandom_range(0, 3)),
                                  (i == len - 1) ? ka : 2'($urandom()),
                                  (i == len - 1) ? kb : 2'($urandom()), i == len - 1);
            endcase
            maybe_gap();
         end
         count += len;
      end
      // a long run of full scale pairs to push the square sums high
      for (int i = 0; i < 300; i++) send_pair(16'h8000, 16'h8000, KIND_IMAGE, KIND_IMAGE,
                                               i == 299);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      stalls_on = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/vcs_pkg.sv
sv/vcs_ctrl.sv
sv/vcs_datapath.sv
sv/vector_cosine_similarity_core.sv
tb/vector_cosine_similarity_core_checker.sv
tb/vector_cosine_similarity_core_tb.sv
